FILE: rtl/mbdt_pkg.sv
// Shared types, constants and register codes for the multi-button debounce block.
`timescale 1ns / 1ps
package mbdt_pkg;

   // Default number of buttons held in the state memory
   localparam int NUM_BUTTONS_DEF = 16;

   // Field widths
   localparam int BTN_W   = 4;
   localparam int TIME_W  = 32;
   localparam int MASK_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Reset values of the timing registers
   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_RESET_MS      = 16'd20;
   localparam logic [CSR_DATA_W-1:0] FAST_TOGGLE_RESET_MS   = 16'd10;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED    = 3'd0,
      CSR_ACTIVE_LOW = 3'd1,
      CSR_FUNCTION   = 3'd2,
      CSR_TOGGLE     = 3'd3,
      CSR_EMERGENCY  = 3'd4,
      CSR_DEBOUNCE   = 3'd5,
      CSR_FAST_MIN   = 3'd6
   } csr_index_type;

   // Event kinds
   localparam logic EV_FUNCTION  = 1'b0;
   localparam logic EV_IMMEDIATE = 1'b1;

   // Debounce phase, one-hot
   typedef enum logic [4:0] {
      PH_IDLE          = 5'b00001,
      PH_PRESS_NOISE   = 5'b00010,
      PH_ACTIVE        = 5'b00100,
      PH_RELEASE_NOISE = 5'b01000,
      PH_LATCH_WAIT    = 5'b10000
   } phase_type;

   // One button's stored state
   typedef struct packed {
      phase_type          phase;
      logic               prev_raw;
      logic [TIME_W-1:0]  start_time;
      logic               latch;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      phase: PH_IDLE, prev_raw: 1'b0, start_time: '0, latch: 1'b0};

   // Configuration register set
   typedef struct packed {
      logic [MASK_W-1:0]     enabled;
      logic [MASK_W-1:0]     active_low;
      logic [MASK_W-1:0]     function_bits;
      logic [MASK_W-1:0]     toggle;
      logic [MASK_W-1:0]     emergency;
      logic [CSR_DATA_W-1:0] debounce_ms;
      logic [CSR_DATA_W-1:0] fast_min_ms;
   } cfg_type;

   // Result word of one step
   typedef struct packed {
      logic valid;
      logic kind;
      logic on;
   } event_type;

endpackage

FILE: rtl/mbdt_csr.sv
// Configuration register file for the debounce block.
`timescale 1ns / 1ps
module mbdt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbdt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbdt_pkg::CSR_DATA_W-1:0] csr_data,
   output mbdt_pkg::cfg_type               cfg
);
   import mbdt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // Register decode; unused indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLED:    cfg_in.enabled       = csr_data;
            CSR_ACTIVE_LOW: cfg_in.active_low    = csr_data;
            CSR_FUNCTION:   cfg_in.function_bits = csr_data;
            CSR_TOGGLE:     cfg_in.toggle        = csr_data;
            CSR_EMERGENCY:  cfg_in.emergency     = csr_data;
            CSR_DEBOUNCE:   cfg_in.debounce_ms   = csr_data;
            CSR_FAST_MIN:   cfg_in.fast_min_ms   = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enabled: '0, active_low: '0, function_bits: '0, toggle: '0,
                     emergency: '0, debounce_ms: DEBOUNCE_RESET_MS,
                     fast_min_ms: FAST_TOGGLE_RESET_MS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/mbdt_state_mem.sv
// Per-button state memory with valid bits and write-to-read forwarding.
`timescale 1ns / 1ps
module mbdt_state_mem #(
   parameter int NUM_BUTTONS = mbdt_pkg::NUM_BUTTONS_DEF,
   parameter int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output mbdt_pkg::entry_type rd_entry,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  mbdt_pkg::entry_type wr_entry
);
   import mbdt_pkg::*;

   entry_type             mem [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] valid_ff;
   entry_type             rd_data_ff;
   logic                  rd_valid_ff;
   logic                  fwd_ff;
   entry_type             fwd_data_ff;

   // Storage write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= wr_entry;
      end
   end

   // Entry valid bits, cleared at reset; forward select for same-entry overlap
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
            fwd_ff      <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   assign rd_entry = fwd_ff      ? fwd_data_ff :
                     rd_valid_ff ? rd_data_ff  : ENTRY_RESET;

endmodule

FILE: rtl/mbdt_step.sv
// Debounce phase update and event generation for one button sample.
`timescale 1ns / 1ps
module mbdt_step (
   input  mbdt_pkg::entry_type               cur,
   input  logic                              raw,
   input  logic [mbdt_pkg::TIME_W-1:0]       now,
   input  logic                              active_low,
   input  logic                              emerg,
   input  logic                              is_fn,
   input  logic                              tog,
   input  logic [mbdt_pkg::CSR_DATA_W-1:0]   debounce_ms,
   input  logic [mbdt_pkg::CSR_DATA_W-1:0]   fast_min_ms,
   output mbdt_pkg::entry_type               nxt,
   output mbdt_pkg::event_type               ev
);
   import mbdt_pkg::*;

   logic              pressed;
   logic              was_pressed;
   logic              edge_seen;
   entry_type         mid;
   logic [TIME_W-1:0] held;
   logic              deb_done;
   logic              fast_done;

   assign pressed     = raw ^ active_low;
   assign was_pressed = cur.prev_raw ^ active_low;
   assign edge_seen   = raw != cur.prev_raw;

   // Raw edge bookkeeping
   always_comb begin
      mid = cur;
      if (edge_seen) begin
         mid.prev_raw   = raw;
         mid.start_time = now;
         if (emerg && !pressed && was_pressed) begin
            mid.phase = PH_IDLE;
         end
      end
   end

   // Elapsed time since phase start, wrapping
   assign held      = now - mid.start_time;
   assign deb_done  = held >= {{(TIME_W-CSR_DATA_W){1'b0}}, debounce_ms};
   assign fast_done = held >= {{(TIME_W-CSR_DATA_W){1'b0}}, fast_min_ms};

   // Phase machine
   always_comb begin
      nxt = mid;
      ev  = '{valid: 1'b0, kind: EV_FUNCTION, on: 1'b0};
      if (emerg) begin
         if (edge_seen && pressed) begin
            nxt.phase = PH_PRESS_NOISE;
            ev = '{valid: 1'b1, kind: EV_IMMEDIATE, on: 1'b0};
         end
      end else begin
         unique case (mid.phase)
            PH_PRESS_NOISE: begin
               if (!pressed) begin
                  nxt.phase = PH_IDLE;
                  if (is_fn && tog && fast_done) begin
                     nxt.latch = ~mid.latch;
                     ev = '{valid: 1'b1, kind: EV_FUNCTION, on: ~mid.latch};
                  end
               end else if (deb_done) begin
                  if (is_fn && tog) begin
                     nxt.latch = ~mid.latch;
                     nxt.phase = PH_LATCH_WAIT;
                     ev = '{valid: 1'b1, kind: EV_FUNCTION, on: ~mid.latch};
                  end else begin
                     nxt.phase = PH_ACTIVE;
                     if (is_fn) begin
                        ev = '{valid: 1'b1, kind: EV_FUNCTION, on: 1'b1};
                     end else begin
                        ev = '{valid: 1'b1, kind: EV_IMMEDIATE, on: 1'b0};
                     end
                  end
               end
            end
            PH_ACTIVE: begin
               if (!pressed) begin
                  nxt.phase      = PH_RELEASE_NOISE;
                  nxt.start_time = now;
               end
            end
            PH_RELEASE_NOISE: begin
               if (pressed) begin
                  nxt.phase = PH_ACTIVE;
               end else if (deb_done) begin
                  nxt.phase = PH_IDLE;
                  if (is_fn && !tog) begin
                     ev = '{valid: 1'b1, kind: EV_FUNCTION, on: 1'b0};
                  end
               end
            end
            PH_LATCH_WAIT: begin
               if (!pressed) begin
                  nxt.start_time = now;
                  nxt.phase = (debounce_ms == '0) ? PH_IDLE : PH_RELEASE_NOISE;
               end
            end
            default: begin
               nxt.phase = PH_IDLE;
               if (pressed) begin
                  nxt.phase      = PH_PRESS_NOISE;
                  nxt.start_time = now;
               end
            end
         endcase
      end
   end

endmodule

FILE: rtl/multi_button_debounce_toggle_top.sv
// Top level of the multi-button debounce and toggle block.
`timescale 1ns / 1ps
// Usage:
//   req_*  : one raw pin sample word (button index, level, ms time) per accept;
//            a word is taken when req_valid is high and req_stall is low.
//   rsp_*  : zero or one event word per sample (button, kind, on/off),
//            taken when rsp_valid is high and rsp_stall is low.
//   csr_*  : register writes by index; csr_ready is always high. Write only
//            while no sample is in flight.
// Timing: a sample enters every cycle while req_stall is low. Per-button
//   state sits in a memory with a registered read; the sample is evaluated in
//   the cycle after accept and written back, and a back-to-back sample of the
//   same button takes the write data over the forward path. An event is
//   registered from the evaluation stage into the output register.
// Reset: synchronous; all buttons return to idle with level and latch 0,
//   masks clear, debounce 20 ms and fast toggle 10 ms. Per-entry valid bits
//   stand in for clearing the memory, so no sweep is needed.
// Stall: while an event waits under rsp_stall, the evaluation stage holds
//   and req_stall rises once that stage is occupied.
module multi_button_debounce_toggle_top #(
   parameter int NUM_BUTTONS = mbdt_pkg::NUM_BUTTONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mbdt_pkg::BTN_W-1:0]      req_button_index,
   input  logic                            req_raw_level,
   input  logic [mbdt_pkg::TIME_W-1:0]     req_time_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mbdt_pkg::BTN_W-1:0]      rsp_event_button,
   output logic                            rsp_event_kind,
   output logic                            rsp_function_on,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbdt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbdt_pkg::CSR_DATA_W-1:0] csr_data
);
   import mbdt_pkg::*;

   localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   cfg_type   cfg;
   entry_type cur_entry;
   entry_type nxt_entry;
   event_type step_ev;

   logic              accept;
   logic              in_range;
   logic [AW+BTN_W-1:0] req_addr_ext;
   logic [AW-1:0]     req_addr;
   logic [AW+BTN_W-1:0] s1_addr_ext;

   logic              s1_valid_ff, s1_valid_in;
   logic [BTN_W-1:0]  s1_button_ff;
   logic              s1_raw_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic              s1_range_ff;
   logic              s1_effective;
   logic              s1_advance;
   logic              out_block;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BTN_W-1:0]  rsp_button_ff;
   logic              rsp_kind_ff;
   logic              rsp_on_ff;

   // Configuration registers
   mbdt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake and stage control
   assign out_block  = rsp_valid_ff && rsp_stall;
   assign req_stall  = s1_valid_ff && out_block;
   assign accept     = req_valid && !req_stall;
   assign s1_advance = s1_valid_ff && !out_block;

   // Address of the incoming sample; out-of-range buttons read entry 0
   assign in_range     = {3'b000, req_button_index} < 7'(NUM_BUTTONS);
   assign req_addr_ext = {{AW{1'b0}}, req_button_index};
   assign req_addr     = in_range ? req_addr_ext[AW-1:0] : '0;
   assign s1_addr_ext  = {{AW{1'b0}}, s1_button_ff};

   // Button takes part only when in range and enabled
   assign s1_effective = s1_range_ff && cfg.enabled[s1_button_ff];

   mbdt_state_mem #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .AW          (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_addr),
      .rd_entry (cur_entry),
      .wr_en    (s1_advance && s1_effective),
      .wr_addr  (s1_addr_ext[AW-1:0]),
      .wr_entry (nxt_entry)
   );

   mbdt_step u_step (
      .cur         (cur_entry),
      .raw         (s1_raw_ff),
      .now         (s1_time_ff),
      .active_low  (cfg.active_low[s1_button_ff]),
      .emerg       (cfg.emergency[s1_button_ff]),
      .is_fn       (!cfg.emergency[s1_button_ff] && cfg.function_bits[s1_button_ff]),
      .tog         (cfg.toggle[s1_button_ff]),
      .debounce_ms (cfg.debounce_ms),
      .fast_min_ms (cfg.fast_min_ms),
      .nxt         (nxt_entry),
      .ev          (step_ev)
   );

   // Evaluation stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_button_ff <= req_button_index;
         s1_raw_ff    <= req_raw_level;
         s1_time_ff   <= req_time_ms;
         s1_range_ff  <= in_range;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_effective && step_ev.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_effective && step_ev.valid) begin
         rsp_button_ff <= s1_button_ff;
         rsp_kind_ff   <= step_ev.kind;
         rsp_on_ff     <= step_ev.on;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_button = rsp_button_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_function_on  = rsp_on_ff;

endmodule

FILE: tb/mbdt_event_check.sv
// Checker: predicts debounce events from accepted samples and compares them with the event channel.
`timescale 1ns / 1ps
module mbdt_event_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [mbdt_pkg::BTN_W-1:0]      req_button_index,
   input  logic                            req_raw_level,
   input  logic [mbdt_pkg::TIME_W-1:0]     req_time_ms,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [mbdt_pkg::BTN_W-1:0]      rsp_event_button,
   input  logic                            rsp_event_kind,
   input  logic                            rsp_function_on,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [mbdt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbdt_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              outstanding
);
   import mbdt_pkg::*;

   typedef struct packed {
      logic [BTN_W-1:0] button;
      logic             kind;
      logic             on;
   } button_event_t;

   // shadow copy of the register set and per-button state
   cfg_type           regs;
   phase_type         phase_of   [NUM_BUTTONS_DEF];
   logic              level_seen [NUM_BUTTONS_DEF];
   logic [TIME_W-1:0] phase_t0   [NUM_BUTTONS_DEF];
   logic              latch_of   [NUM_BUTTONS_DEF];

   // events predicted but not yet seen on the event channel
   button_event_t expected_events[$];

   task automatic note_failure(input string what, input button_event_t want,
                               input button_event_t got);
      if (fail_count < 10)
         $display("%0t %s: expected button %0d kind %0d on %0d, got button %0d kind %0d on %0d",
                  $time, what, want.button, want.kind, want.on, got.button, got.kind, got.on);
      fail_count++;
   endtask

   // one sample through the debounce machine; returns 1 when an event is due
   function automatic bit debounce_step(input logic [BTN_W-1:0] b, input logic raw,
                                        input logic [TIME_W-1:0] now,
                                        output button_event_t ev);
      logic emerg, is_fn, tog, pressed, was;
      logic [TIME_W-1:0] held;
      ev = '{button: b, kind: EV_FUNCTION, on: 1'b0};
      if (!regs.enabled[b]) return 0;
      emerg   = regs.emergency[b];
      is_fn   = !emerg && regs.function_bits[b];
      tog     = regs.toggle[b];
      pressed = regs.active_low[b] ? !raw : raw;

      // raw edge: restart the timer; emergency buttons fire on the pressed edge
      if (raw != level_seen[b]) begin
         was = regs.active_low[b] ? !level_seen[b] : level_seen[b];
         level_seen[b] = raw;
         phase_t0[b] = now;
         if (emerg) begin
            if (pressed) begin
               phase_of[b] = PH_PRESS_NOISE;
               ev.kind = EV_IMMEDIATE;
               return 1;
            end
            if (was) phase_of[b] = PH_IDLE;
         end
      end
      if (emerg) return 0;

      held = now - phase_t0[b];
      case (phase_of[b])
         PH_PRESS_NOISE: begin
            if (!pressed) begin
               // short press may still toggle
               phase_of[b] = PH_IDLE;
               if (is_fn && tog && held >= regs.fast_min_ms) begin
                  latch_of[b] = !latch_of[b];
                  ev.on = latch_of[b];
                  return 1;
               end
               return 0;
            end
            if (held >= regs.debounce_ms) begin
               if (is_fn && tog) begin
                  latch_of[b] = !latch_of[b];
                  phase_of[b] = PH_LATCH_WAIT;
                  ev.on = latch_of[b];
                  return 1;
               end
               phase_of[b] = PH_ACTIVE;
               if (is_fn) ev.on = 1'b1;
               else ev.kind = EV_IMMEDIATE;
               return 1;
            end
         end
         PH_ACTIVE: begin
            if (!pressed) begin
               phase_of[b] = PH_RELEASE_NOISE;
               phase_t0[b] = now;
            end
         end
         PH_RELEASE_NOISE: begin
            if (pressed) begin
               phase_of[b] = PH_ACTIVE;
            end else if (held >= regs.debounce_ms) begin
               phase_of[b] = PH_IDLE;
               // momentary function button reports off
               if (is_fn && !tog) return 1;
            end
         end
         PH_LATCH_WAIT: begin
            if (!pressed) begin
               phase_t0[b] = now;
               phase_of[b] = (regs.debounce_ms == '0) ? PH_IDLE : PH_RELEASE_NOISE;
            end
         end
         default: begin
            phase_of[b] = PH_IDLE;
            if (pressed) begin
               phase_of[b] = PH_PRESS_NOISE;
               phase_t0[b] = now;
            end
         end
      endcase
      return 0;
   endfunction

   // register writes, event compare, then prediction of the new sample
   always @(posedge clock) begin
      button_event_t want, got, ev;
      if (reset) begin
         regs = '{enabled: '0, active_low: '0, function_bits: '0, toggle: '0,
                  emergency: '0, debounce_ms: DEBOUNCE_RESET_MS,
                  fast_min_ms: FAST_TOGGLE_RESET_MS};
         for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
            phase_of[i]   = PH_IDLE;
            level_seen[i] = 1'b0;
            phase_t0[i]   = '0;
            latch_of[i]   = 1'b0;
         end
         expected_events.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLED:    regs.enabled       = csr_data;
               CSR_ACTIVE_LOW: regs.active_low    = csr_data;
               CSR_FUNCTION:   regs.function_bits = csr_data;
               CSR_TOGGLE:     regs.toggle        = csr_data;
               CSR_EMERGENCY:  regs.emergency     = csr_data;
               CSR_DEBOUNCE:   regs.debounce_ms   = csr_data;
               CSR_FAST_MIN:   regs.fast_min_ms   = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{button: rsp_event_button, kind: rsp_event_kind, on: rsp_function_on};
            if (expected_events.size() == 0) begin
               note_failure("event word with nothing pending", '0, got);
            end else begin
               want = expected_events.pop_front();
               if (got.button !== want.button || got.kind !== want.kind ||
                   got.on !== want.on)
                  note_failure("event word differs", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            if (debounce_step(req_button_index, req_raw_level, req_time_ms, ev))
               expected_events.push_back(ev);
         end
      end
      outstanding <= expected_events.size();
   end

endmodule

FILE: tb/multi_button_debounce_toggle_top_test.sv
// Testbench top: clock, reset, sample and register stimulus, and the final verdict.
`timescale 1ns / 1ps
module multi_button_debounce_toggle_top_test;
   import mbdt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 120;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [BTN_W-1:0]      req_button_index;
   logic                  req_raw_level;
   logic [TIME_W-1:0]     req_time_ms;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BTN_W-1:0]      rsp_event_button;
   logic                  rsp_event_kind;
   logic                  rsp_function_on;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int  fail_count;
   int  outstanding;
   int  cycle_count;
   bit  no_gaps;
   int  holds_asked;
   int  holds_begun;

   // stimulus bookkeeping
   logic              pin_level [16];
   logic [TIME_W-1:0] clock_ms;
   int                cur_deb;
   int                focus [3];

   always #5 clock = ~clock;

   multi_button_debounce_toggle_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_index (req_button_index),
      .req_raw_level    (req_raw_level),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_function_on  (rsp_function_on),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   mbdt_event_check u_event_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_index (req_button_index),
      .req_raw_level    (req_raw_level),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_function_on  (rsp_function_on),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // event receiver: random stalls, plus long hold-offs on request
   initial begin : event_receiver
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_begun != holds_asked) begin
            holds_begun++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (no_gaps) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 11);
         end
      end
   end

   // one sample word, with random idle cycles ahead of it
   task automatic offer_sample(input logic [BTN_W-1:0] b, input logic raw,
                               input logic [TIME_W-1:0] t);
      while (!no_gaps && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_button_index <= b;
      req_raw_level    <= raw;
      req_time_ms      <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for every predicted event
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // drained plus pipeline latency: safe point for register writes
   task automatic settle();
      drain();
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_settings(input logic [15:0] en, input logic [15:0] act_low,
                                input logic [15:0] fn, input logic [15:0] tg,
                                input logic [15:0] em, input logic [15:0] deb,
                                input logic [15:0] fast_min);
      settle();
      write_reg(CSR_ENABLED, en);
      write_reg(CSR_ACTIVE_LOW, act_low);
      write_reg(CSR_FUNCTION, fn);
      write_reg(CSR_TOGGLE, tg);
      write_reg(CSR_EMERGENCY, em);
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_FAST_MIN, fast_min);
      csr_valid <= 1'b0;
      cur_deb = int'(deb);
   endtask

   function automatic logic [15:0] random_mask();
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // random sample: mostly a few focus buttons, level usually held, time steps
   // scaled to the debounce delay so presses and releases complete
   task automatic random_sample();
      int b, r;
      logic [TIME_W-1:0] step;
      if ($urandom_range(99) < 80) b = focus[$urandom_range(2)];
      else b = $urandom_range(15);
      if ($urandom_range(99) < 28) pin_level[b] = !pin_level[b];
      r = $urandom_range(99);
      if (r < 55) step = $urandom_range(0, cur_deb / 3 + 2);
      else if (r < 90) step = $urandom_range(cur_deb / 2, cur_deb + 3);
      else if (r < 98) step = $urandom_range(0, 300);
      else step = $urandom;
      clock_ms += step;
      offer_sample(b[BTN_W-1:0], pin_level[b], clock_ms);
   endtask

   // directed words: ignored button, emergency edge, toggle, momentary,
   // plain action, active-low, debounce boundary and time wrap
   task automatic directed_part();
      offer_sample(4'd3, 1'b1, 32'h0000_0000);
      load_settings(16'hFFFF, 16'h00F0, 16'h0F0F, 16'h0303, 16'h1111, 16'd20, 16'd10);
      // emergency wins over function on button 0
      offer_sample(4'd0, 1'b1, 32'd100);
      offer_sample(4'd0, 1'b1, 32'd130);
      offer_sample(4'd0, 1'b0, 32'd140);
      // toggle button 1: latch on, then release through latched wait
      offer_sample(4'd1, 1'b1, 32'd200);
      offer_sample(4'd1, 1'b1, 32'd225);
      offer_sample(4'd1, 1'b0, 32'd230);
      offer_sample(4'd1, 1'b0, 32'd260);
      // momentary button 2: on at the exact debounce time, release bounce, off
      offer_sample(4'd2, 1'b1, 32'd400);
      offer_sample(4'd2, 1'b1, 32'd420);
      offer_sample(4'd2, 1'b0, 32'd425);
      offer_sample(4'd2, 1'b1, 32'd430);
      offer_sample(4'd2, 1'b0, 32'd435);
      offer_sample(4'd2, 1'b0, 32'd454);
      offer_sample(4'd2, 1'b0, 32'd455);
      // plain button 13: immediate action one ms after the short miss
      offer_sample(4'd13, 1'b1, 32'd500);
      offer_sample(4'd13, 1'b1, 32'd519);
      offer_sample(4'd13, 1'b1, 32'd520);
      // active-low button 5 pressed with no raw edge
      offer_sample(4'd5, 1'b0, 32'd600);
      offer_sample(4'd5, 1'b0, 32'd620);
      // momentary button 3 across the time wrap
      offer_sample(4'd3, 1'b1, 32'hFFFF_FFF8);
      offer_sample(4'd3, 1'b1, 32'h0000_000C);
      offer_sample(4'd3, 1'b0, 32'hFFFF_FFFF);
      offer_sample(4'd3, 1'b0, 32'h0000_0013);
   endtask

   initial begin : stimulus
      int p, n, k;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_button_index <= '0;
      req_raw_level    <= 1'b0;
      req_time_ms      <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_ENABLED;
      csr_data         <= '0;
      no_gaps          <= 1'b0;
      holds_asked      <= 0;
      for (k = 0; k < 16; k++) pin_level[k] = 1'b0;
      clock_ms = '0;
      cur_deb = 20;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      directed_part();

      // random phases over a range of register settings
      for (p = 0; p < 10; p++) begin
         case (p)
            0: load_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'h00FF, 16'h0000, 16'd8, 16'd3);
            1: load_settings(random_mask(), 16'hFFFF, random_mask(), random_mask(),
                             random_mask(), 16'($urandom_range(0, 40)),
                             16'($urandom_range(0, 40)));
            2: load_settings(16'hFFFF, random_mask(), random_mask(), random_mask(),
                             random_mask(), 16'd0, 16'd0);
            3: load_settings(16'hFFFF, random_mask(), 16'hFFFF, 16'hFFFF, 16'h0000,
                             16'hFFFF, 16'hFFFF);
            4: load_settings(16'h0000, random_mask(), random_mask(), random_mask(),
                             random_mask(), 16'd20, 16'd10);
            5: load_settings(16'hFFFF, random_mask(), random_mask(), random_mask(),
                             16'hFFFF, 16'd5, 16'd2);
            6: load_settings(16'hFFFF, random_mask(), random_mask(), 16'hFFFF, 16'h0000,
                             16'd10, 16'd30);
            7: load_settings(random_mask(), random_mask(), random_mask(), random_mask(),
                             random_mask(), 16'($urandom_range(0, 60)),
                             16'($urandom_range(0, 60)));
            8: load_settings(16'hFFFF, random_mask(), random_mask(), random_mask(),
                             random_mask(), 16'd1, 16'd0);
            default: load_settings(16'hFFFF, random_mask(), 16'hFFFF, random_mask(),
                                   random_mask(), 16'd30, 16'd0);
         endcase
         no_gaps <= (p == 2);
         clock_ms = (p == 3) ? 32'hFFFF_FF00 : $urandom;
         for (n = 0; n < ((p == 4) ? 30 : 115); n++) begin
            if (n % 40 == 0)
               for (k = 0; k < 3; k++) focus[k] = $urandom_range(15);
            // long receiver hold-off while samples keep coming
            if (p == 0 && n == 20) holds_asked <= holds_asked + 1;
            // sender pause until everything has come back
            if (p == 1 && n == 60) drain();
            random_sample();
         end
      end

      settle();
      if (fail_count == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
